// File: sv/assert_macros.svh
// Assertion macros used by the pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at the same clock edge.
`define BRP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication that must hold at the following clock edge.
`define BRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/brp_pkg.sv
// ----------------------------------------------------------------------------
// brp_pkg
// Types, constants and codes for the buffer recycling pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brp_pkg;

  localparam int FREE_DEPTH = 32;
  localparam int USED_DEPTH = 64;
  localparam int HANDLE_W   = 32;
  localparam int SIZE_W     = 24;
  localparam int AGE_W      = 8;
  localparam int FA_W       = $clog2(FREE_DEPTH);
  localparam int UA_W       = $clog2(USED_DEPTH);
  localparam int FC_W       = $clog2(FREE_DEPTH + 1);
  localparam int UC_W       = $clog2(USED_DEPTH + 1);
  localparam int IDX_W      = (UC_W > FC_W) ? UC_W : FC_W;
  localparam int FREE_W     = HANDLE_W + SIZE_W + AGE_W;
  localparam int USED_W     = HANDLE_W + SIZE_W;

  localparam logic [SIZE_W-1:0] RESERVE_RESET = 24'd258944;
  localparam logic [AGE_W-1:0]  AGE_LIMIT_RESET = 8'd3;
  localparam logic [AGE_W-1:0]  AGE_MAX = '1;

  // Operation codes.
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_FLUSH   = 2'd3;

  // Result status codes.
  localparam logic [3:0] ST_REUSED  = 4'd0;
  localparam logic [3:0] ST_NEW     = 4'd1;
  localparam logic [3:0] ST_FAILED  = 4'd2;
  localparam logic [3:0] ST_FULL    = 4'd3;
  localparam logic [3:0] ST_POOLED  = 4'd4;
  localparam logic [3:0] ST_PASS    = 4'd5;
  localparam logic [3:0] ST_AGED    = 4'd6;
  localparam logic [3:0] ST_FLUSHED = 4'd7;
  localparam logic [3:0] ST_NOTHING = 4'd8;

  // Configuration register indexes.
  localparam logic REG_RESERVE   = 1'b0;
  localparam logic REG_AGE_LIMIT = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_A_MUL, S_A_RND, S_A_FULL, S_A_RD, S_A_CHK, S_A_LAST, S_A_MOVE,
    S_A_REUSE, S_A_NEW, S_R_RD, S_R_CHK, S_R_LAST, S_R_MOVE, S_R_POOL,
    S_T_RD, S_T_CHK, S_T_LAST, S_T_MOVE, S_F_RD, S_F_CHK, S_FIN
  } state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [AGE_W-1:0]    age;
  } free_entry_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } used_entry_t;

  typedef struct packed {
    logic [3:0]          status;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [SIZE_W-1:0]   copy;
  } result_t;

endpackage

`default_nettype wire

// File: sv/buffer_recycle_pool_with_aging.sv
// ----------------------------------------------------------------------------
// buffer_recycle_pool_with_aging
// Recycling pool for buffer handles with size classes and aging of free
// entries; free and in-use tables are held in two synchronous memories.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | words
//  ---------+-----------+---------------------+-------------------------------
//  in       | input     | in_valid / in_stall | one request per word
//  out      | output    | out_valid/out_stall | one or more results per request
//  cfg      | input     | APB write, pready=1 | reserve_size, age_limit
//
// One request is handled at a time; in_stall is high until its last result has
// been placed in the output register. Allocate runs up to 25 rounding steps and
// then searches the free entries; release searches the in-use entries, tick and
// flush walk the free entries, and a tick also moves each entry that ages out.
// Each search step issues a memory read and then checks the registered data.
// Reset clears both counts at once. A stalled output register holds the engine
// where it would emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module buffer_recycle_pool_with_aging (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   operation,
  input  wire logic [15:0]                  vertex_count,
  input  wire logic [7:0]                   vertex_size,
  input  wire logic [brp_pkg::HANDLE_W-1:0] handle,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [3:0]                        status,
  output logic [brp_pkg::HANDLE_W-1:0]      out_handle,
  output logic [brp_pkg::SIZE_W-1:0]        buffer_size,
  output logic [brp_pkg::SIZE_W-1:0]        copy_bytes,
  output logic                              last,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  import brp_pkg::*;

  `include "assert_macros.svh"

  state_t state, state_next;

  logic [SIZE_W-1:0]   reserve_size;
  logic [AGE_W-1:0]    age_limit;
  logic [1:0]          op;
  logic [15:0]         cnt;
  logic [7:0]          vsz;
  logic [HANDLE_W-1:0] hnd;
  logic [SIZE_W-1:0]   bytes;
  logic [SIZE_W-1:0]   ms;
  logic [SIZE_W:0]     rnd;
  logic [IDX_W-1:0]    idx;
  logic [FC_W-1:0]     fcount;
  logic [UC_W-1:0]     ucount;
  logic [HANDLE_W-1:0] cur_h;
  logic [SIZE_W-1:0]   cur_sz;
  result_t             pend;
  logic                pend_valid;

  // Memory ports.
  logic              f_we, f_re, u_we, u_re;
  logic [FA_W-1:0]   f_waddr, f_raddr;
  logic [UA_W-1:0]   u_waddr, u_raddr;
  free_entry_t       f_wdata, f_rdata;
  used_entry_t       u_wdata, u_rdata;

  // Control strobes.
  logic              in_acc, out_acc, emit_ok, prod_ok, prod, fin;
  result_t           prod_res;
  logic              rnd_done, f_more, u_more, fit, age_out;
  logic [AGE_W-1:0]  age_inc;

  brp_ram #(.WIDTH(FREE_W), .DEPTH(FREE_DEPTH)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
  );

  brp_ram #(.WIDTH(USED_W), .DEPTH(USED_DEPTH)) u_used_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .re(u_re), .raddr(u_raddr), .rdata(u_rdata)
  );

  // Handshake conditions.
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign emit_ok  = !out_valid || !out_stall;
  assign prod_ok  = !pend_valid || emit_ok;

  // Comparisons used by the scans.
  assign rnd_done = (rnd > {1'b0, reserve_size}) || (rnd >= {1'b0, bytes});
  assign f_more   = (idx < IDX_W'(fcount));
  assign u_more   = (idx < IDX_W'(ucount));
  assign fit      = (ms <= f_rdata.size) && ({2'b00, f_rdata.size} <= {ms, 2'b00});
  assign age_inc  = (f_rdata.age == AGE_MAX) ? AGE_MAX : f_rdata.age + 1'b1;
  assign age_out  = (age_inc > age_limit);

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2] == REG_AGE_LIMIT) begin
      prdata = {24'd0, age_limit};
    end else begin
      prdata = {8'd0, reserve_size};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserve_size <= RESERVE_RESET;
      age_limit    <= AGE_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_AGE_LIMIT) begin
        age_limit <= pwdata[AGE_W-1:0];
      end else begin
        reserve_size <= pwdata[SIZE_W-1:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (operation)
            OP_ALLOC:   state_next = S_A_MUL;
            OP_RELEASE: state_next = S_R_RD;
            OP_TICK:    state_next = S_T_RD;
            default:    state_next = S_F_RD;
          endcase
        end
      end
      S_A_MUL: state_next = S_A_RND;
      S_A_RND: begin
        if (rnd_done) begin
          state_next = (ucount >= UC_W'(USED_DEPTH)) ? S_A_FULL : S_A_RD;
        end
      end
      S_A_FULL:  if (prod_ok) state_next = S_FIN;
      S_A_RD:    state_next = f_more ? S_A_CHK : S_A_NEW;
      S_A_CHK:   state_next = fit ? S_A_LAST : S_A_RD;
      S_A_LAST:  state_next = S_A_MOVE;
      S_A_MOVE:  state_next = S_A_REUSE;
      S_A_REUSE: if (prod_ok) state_next = S_FIN;
      S_A_NEW:   if (prod_ok) state_next = S_FIN;
      S_R_RD: begin
        if (u_more) begin
          state_next = S_R_CHK;
        end else if (prod_ok) begin
          state_next = S_FIN;
        end
      end
      S_R_CHK:  state_next = (u_rdata.handle == hnd) ? S_R_LAST : S_R_RD;
      S_R_LAST: state_next = S_R_MOVE;
      S_R_MOVE: state_next = S_R_POOL;
      S_R_POOL: if (prod_ok) state_next = S_FIN;
      S_T_RD:   state_next = f_more ? S_T_CHK : S_FIN;
      S_T_CHK:  state_next = age_out ? S_T_LAST : S_T_RD;
      S_T_LAST: state_next = S_T_MOVE;
      S_T_MOVE: if (prod_ok) state_next = S_T_RD;
      S_F_RD:   state_next = f_more ? S_F_CHK : S_FIN;
      S_F_CHK:  if (prod_ok) state_next = S_F_RD;
      S_FIN:    if (emit_ok) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory accesses and result production for each state.
  always_comb begin
    f_we     = 1'b0;
    f_waddr  = idx[FA_W-1:0];
    f_wdata  = f_rdata;
    f_re     = 1'b0;
    f_raddr  = idx[FA_W-1:0];
    u_we     = 1'b0;
    u_waddr  = ucount[UA_W-1:0];
    u_wdata  = '{handle: cur_h, size: cur_sz};
    u_re     = 1'b0;
    u_raddr  = idx[UA_W-1:0];
    prod     = 1'b0;
    prod_res = '{status: ST_NOTHING, handle: '0, size: '0, copy: '0};
    fin      = 1'b0;
    case (state)
      S_A_FULL: begin
        prod     = prod_ok;
        prod_res = '{status: ST_FULL, handle: hnd, size: ms, copy: '0};
      end
      S_A_RD: begin
        f_re = f_more;
      end
      S_A_LAST, S_T_LAST: begin
        f_re    = 1'b1;
        f_raddr = FA_W'(fcount - 1'b1);
      end
      S_A_MOVE: begin
        // Swap the last free entry into the hole and record the grant.
        f_we = 1'b1;
        u_we = 1'b1;
      end
      S_A_REUSE: begin
        prod     = prod_ok;
        prod_res = '{status: ST_REUSED, handle: cur_h, size: cur_sz, copy: bytes};
      end
      S_A_NEW: begin
        prod = prod_ok;
        if (hnd == '0) begin
          prod_res = '{status: ST_FAILED, handle: '0, size: ms, copy: '0};
        end else begin
          u_we     = prod_ok;
          u_wdata  = '{handle: hnd, size: ms};
          prod_res = '{status: ST_NEW, handle: hnd, size: ms, copy: bytes};
        end
      end
      S_R_RD: begin
        u_re = u_more;
        if (!u_more) begin
          prod     = prod_ok;
          prod_res = '{status: ST_PASS, handle: hnd, size: '0, copy: '0};
        end
      end
      S_R_LAST: begin
        u_re    = 1'b1;
        u_raddr = UA_W'(ucount - 1'b1);
      end
      S_R_MOVE: begin
        u_we    = 1'b1;
        u_waddr = idx[UA_W-1:0];
        u_wdata = u_rdata;
      end
      S_R_POOL: begin
        prod = prod_ok;
        if (fcount < FC_W'(FREE_DEPTH)) begin
          f_we     = prod_ok;
          f_waddr  = fcount[FA_W-1:0];
          f_wdata  = '{handle: hnd, size: cur_sz, age: '0};
          prod_res = '{status: ST_POOLED, handle: hnd, size: cur_sz, copy: '0};
        end else begin
          prod_res = '{status: ST_PASS, handle: hnd, size: cur_sz, copy: '0};
        end
      end
      S_T_RD, S_F_RD: begin
        f_re = f_more;
      end
      S_T_CHK: begin
        // A surviving entry gets its new age written back.
        if (!age_out) begin
          f_we    = 1'b1;
          f_wdata = '{handle: f_rdata.handle, size: f_rdata.size, age: age_inc};
        end
      end
      S_T_MOVE: begin
        f_we     = prod_ok;
        prod     = prod_ok;
        prod_res = '{status: ST_AGED, handle: cur_h, size: cur_sz, copy: '0};
      end
      S_F_CHK: begin
        prod     = prod_ok;
        prod_res = '{status: ST_FLUSHED, handle: f_rdata.handle, size: f_rdata.size,
                     copy: '0};
      end
      S_FIN: begin
        fin = emit_ok;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fcount     <= '0;
      ucount     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_A_MOVE: begin
          fcount <= fcount - 1'b1;
          ucount <= ucount + 1'b1;
        end
        S_A_NEW: begin
          if (prod_ok && hnd != '0) begin
            ucount <= ucount + 1'b1;
          end
        end
        S_R_MOVE: ucount <= ucount - 1'b1;
        S_R_POOL: begin
          if (prod_ok && fcount < FC_W'(FREE_DEPTH)) begin
            fcount <= fcount + 1'b1;
          end
        end
        S_T_MOVE: if (prod_ok) fcount <= fcount - 1'b1;
        S_F_RD:   if (!f_more) fcount <= '0;
        default: begin
        end
      endcase
      // A new result pushes the held one out; the held result is sent with the
      // last flag once the request has finished.
      if (prod) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end else if (out_acc) begin
          out_valid <= 1'b0;
        end
      end else if (fin) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op  <= operation;
      cnt <= vertex_count;
      vsz <= vertex_size;
      hnd <= handle;
      idx <= '0;
    end
    case (state)
      S_A_MUL: begin
        bytes <= SIZE_W'({8'd0, cnt} * {16'd0, vsz});
        rnd   <= (SIZE_W + 1)'(1);
      end
      S_A_RND: begin
        if (rnd > {1'b0, reserve_size}) begin
          ms <= bytes;
        end else if (rnd >= {1'b0, bytes}) begin
          ms <= rnd[SIZE_W-1:0];
        end else begin
          rnd <= {rnd[SIZE_W-1:0], 1'b0};
        end
      end
      S_A_CHK: begin
        if (fit) begin
          cur_h  <= f_rdata.handle;
          cur_sz <= f_rdata.size;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      S_R_CHK: begin
        if (u_rdata.handle == hnd) begin
          cur_sz <= u_rdata.size;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      S_T_CHK: begin
        if (age_out) begin
          cur_h  <= f_rdata.handle;
          cur_sz <= f_rdata.size;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      S_F_CHK: if (prod_ok) idx <= idx + 1'b1;
      default: begin
      end
    endcase
    if (prod) begin
      pend <= prod_res;
      if (pend_valid) begin
        status      <= pend.status;
        out_handle  <= pend.handle;
        buffer_size <= pend.size;
        copy_bytes  <= pend.copy;
        last        <= 1'b0;
      end
    end else if (fin) begin
      last <= 1'b1;
      if (pend_valid) begin
        status      <= pend.status;
        out_handle  <= pend.handle;
        buffer_size <= pend.size;
        copy_bytes  <= pend.copy;
      end else begin
        status      <= ST_NOTHING;
        out_handle  <= '0;
        buffer_size <= '0;
        copy_bytes  <= '0;
      end
    end
  end

  // The operation input, not this register, steers the request at acceptance;
  // the register is kept observable for the flush path check below.
  // Assertions.
  `BRP_ASSERT_NOW(a_idle_no_pending, clk, rst, state == S_IDLE, !pend_valid)
  `BRP_ASSERT_NOW(a_counts_bounded, clk, rst, 1'b1,
    fcount <= FC_W'(FREE_DEPTH) && ucount <= UC_W'(USED_DEPTH))
  `BRP_ASSERT_NOW(a_nothing_is_last, clk, rst,
    out_valid && status == ST_NOTHING, last)
  `BRP_ASSERT_NEXT(a_flush_empties, clk, rst,
    state == S_F_RD && !f_more && op == OP_FLUSH, fcount == '0)

endmodule

`default_nettype wire

// File: sv/brp_ram.sv
// ----------------------------------------------------------------------------
// brp_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: verif/brp_pool_checker.sv
// ----------------------------------------------------------------------------
// brp_pool_checker
// Watches the request, result and register channels of the buffer recycling
// pool. It keeps its own copy of the free and in-use tables, works out the
// results of every accepted request and compares them with the returned words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brp_pool_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic [15:0]                  vertex_count,
  input  logic [7:0]                   vertex_size,
  input  logic [brp_pkg::HANDLE_W-1:0] handle,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [3:0]                   status,
  input  logic [brp_pkg::HANDLE_W-1:0] out_handle,
  input  logic [brp_pkg::SIZE_W-1:0]   buffer_size,
  input  logic [brp_pkg::SIZE_W-1:0]   copy_bytes,
  input  logic                         last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output int                           fails,
  output int                           pending
);

  import brp_pkg::*;

  typedef struct {
    logic [3:0]          status;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [SIZE_W-1:0]   copy;
    logic                last;
  } pool_word_t;

  pool_word_t due_words[$];

  logic [SIZE_W-1:0]   reserve_lim;
  logic [AGE_W-1:0]    age_lim;
  logic [HANDLE_W-1:0] free_h [FREE_DEPTH];
  logic [SIZE_W-1:0]   free_sz[FREE_DEPTH];
  logic [AGE_W-1:0]    free_age[FREE_DEPTH];
  int                  free_n;
  logic [HANDLE_W-1:0] used_h [USED_DEPTH];
  logic [SIZE_W-1:0]   used_sz[USED_DEPTH];
  int                  used_n;

  assign pending = due_words.size();

  function automatic void add_word(logic [3:0] st, logic [HANDLE_W-1:0] h,
                                   logic [63:0] sz, logic [63:0] cp);
    pool_word_t w;
    w.status = st;
    w.handle = h;
    w.size   = sz[SIZE_W-1:0];
    w.copy   = cp[SIZE_W-1:0];
    w.last   = 1'b0;
    due_words.insert(due_words.size(), w);
  endfunction

  function automatic void drop_free(int i);
    free_h[i]   = free_h[free_n-1];
    free_sz[i]  = free_sz[free_n-1];
    free_age[i] = free_age[free_n-1];
    free_n--;
  endfunction

  function automatic void drop_used(int i);
    used_h[i]  = used_h[used_n-1];
    used_sz[i] = used_sz[used_n-1];
    used_n--;
  endfunction

  // Works out every result word that one request causes.
  function automatic void pool_predict(logic [1:0] op, logic [15:0] cnt,
                                       logic [7:0] vsz, logic [HANDLE_W-1:0] h);
    logic [63:0] bytes;
    logic [63:0] req;
    logic [63:0] p;
    logic [63:0] sz;
    int          i;
    int          start;
    bit          done;
    start = due_words.size();
    done  = 0;
    case (op)
      OP_ALLOC: begin
        bytes = 64'(cnt) * 64'(vsz);
        // Round up to a power of two no larger than the reserve limit; else keep the byte count.
        req = bytes;
        p = 1;
        while (p <= 64'(reserve_lim)) begin
          if (p >= bytes) begin
            req = p;
            break;
          end
          p = p << 1;
        end
        if (used_n >= USED_DEPTH) begin
          add_word(ST_FULL, h, req, 0);
        end else begin
          for (i = 0; i < free_n; i++) begin
            sz = 64'(free_sz[i]);
            if (req <= sz && req * 4 >= sz) begin
              used_h[used_n]  = free_h[i];
              used_sz[used_n] = free_sz[i];
              used_n++;
              add_word(ST_REUSED, free_h[i], sz, bytes);
              drop_free(i);
              done = 1;
              break;
            end
          end
          if (!done) begin
            if (h == '0) begin
              add_word(ST_FAILED, '0, req, 0);
            end else begin
              used_h[used_n]  = h;
              used_sz[used_n] = req[SIZE_W-1:0];
              used_n++;
              add_word(ST_NEW, h, req, bytes);
            end
          end
        end
      end
      OP_RELEASE: begin
        for (i = 0; i < used_n; i++) begin
          if (used_h[i] == h) begin
            sz = 64'(used_sz[i]);
            drop_used(i);
            if (free_n < FREE_DEPTH) begin
              free_h[free_n]   = h;
              free_sz[free_n]  = sz[SIZE_W-1:0];
              free_age[free_n] = '0;
              free_n++;
              add_word(ST_POOLED, h, sz, 0);
            end else begin
              add_word(ST_PASS, h, sz, 0);
            end
            done = 1;
            break;
          end
        end
        if (!done) add_word(ST_PASS, h, 0, 0);
      end
      OP_TICK: begin
        i = 0;
        while (i < free_n) begin
          if (free_age[i] != AGE_MAX) free_age[i]++;
          if (free_age[i] > age_lim) begin
            add_word(ST_AGED, free_h[i], 64'(free_sz[i]), 0);
            drop_free(i);
          end else begin
            i++;
          end
        end
      end
      default: begin
        for (i = 0; i < free_n; i++) add_word(ST_FLUSHED, free_h[i], 64'(free_sz[i]), 0);
        free_n = 0;
      end
    endcase
    if (due_words.size() == start) add_word(ST_NOTHING, '0, 0, 0);
    due_words[due_words.size()-1].last = 1'b1;
  endfunction

  // Compares one returned word with the oldest one due.
  function automatic void compare_word();
    pool_word_t w;
    if (due_words.size() == 0) begin
      $display("%0t: result word with none due: status %0d handle %h", $realtime,
               status, out_handle);
      fails++;
      return;
    end
    w = due_words.pop_front();
    if (status !== w.status) begin
      $display("%0t: status expected %0d actual %0d", $realtime, w.status, status);
      fails++;
    end
    if (out_handle !== w.handle) begin
      $display("%0t: out_handle expected %h actual %h", $realtime, w.handle, out_handle);
      fails++;
    end
    if (buffer_size !== w.size) begin
      $display("%0t: buffer_size expected %0d actual %0d", $realtime, w.size, buffer_size);
      fails++;
    end
    if (copy_bytes !== w.copy) begin
      $display("%0t: copy_bytes expected %0d actual %0d", $realtime, w.copy, copy_bytes);
      fails++;
    end
    if (last !== w.last) begin
      $display("%0t: last expected %0d actual %0d", $realtime, w.last, last);
      fails++;
    end
  endfunction

  // Monitor all three channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      fails       = 0;
      reserve_lim = RESERVE_RESET;
      age_lim     = AGE_LIMIT_RESET;
      free_n      = 0;
      used_n      = 0;
      due_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'd4 * REG_RESERVE) reserve_lim = pwdata[SIZE_W-1:0];
        else if (paddr == 3'd4 * REG_AGE_LIMIT) age_lim = pwdata[AGE_W-1:0];
      end
      if (out_valid && !out_stall) compare_word();
      if (in_valid && !in_stall) pool_predict(operation, vertex_count, vertex_size, handle);
    end
  end

endmodule

// File: verif/tb_buffer_recycle_pool_with_aging.sv
// ----------------------------------------------------------------------------
// tb_buffer_recycle_pool_with_aging
// Drives requests and register writes into the buffer recycling pool. A
// directed opening covers the special cases; random phases under several
// register settings then fill both tables, age and flush the pool. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_buffer_recycle_pool_with_aging;
  import brp_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          operation;
  logic [15:0]         vertex_count;
  logic [7:0]          vertex_size;
  logic [HANDLE_W-1:0] handle;
  logic                out_valid;
  logic                out_stall;
  logic [3:0]          status;
  logic [HANDLE_W-1:0] out_handle;
  logic [SIZE_W-1:0]   buffer_size;
  logic [SIZE_W-1:0]   copy_bytes;
  logic                last;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  fails;
  int                  pending;

  // Receiver controls and the handles handed out so far.
  bit                  calm;
  bit                  hold_go;
  logic [HANDLE_W-1:0] issued[$];

  buffer_recycle_pool_with_aging u_dut (.*);

  brp_pool_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side stall: random bursts, or one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_go = 0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("buffer_recycle_pool_with_aging: mismatch");
        $finish;
      end
    end
  end

  // Offers one request word and returns once it has been taken.
  task automatic send_req(logic [1:0] op, logic [15:0] cnt, logic [7:0] vsz,
                          logic [HANDLE_W-1:0] h);
    in_valid     <= 1'b1;
    operation    <= op;
    vertex_count <= cnt;
    vertex_size  <= vsz;
    handle       <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'd4 * idx;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] reserve, logic [31:0] age);
    wait_drained();
    write_reg(REG_RESERVE, reserve);
    write_reg(REG_AGE_LIMIT, age);
  endtask

  task automatic rand_alloc();
    logic [15:0]         cnt;
    logic [7:0]          vsz;
    logic [HANDLE_W-1:0] h;
    if ($urandom_range(0, 9) == 0) begin
      cnt = 16'($urandom);
      vsz = 8'($urandom);
    end else begin
      cnt = 16'($urandom_range(0, 64));
      vsz = 8'($urandom_range(0, 8));
    end
    h = ($urandom_range(0, 15) == 0) ? '0 : HANDLE_W'($urandom);
    if (h != '0) issued.insert(issued.size(), h);
    send_req(OP_ALLOC, cnt, vsz, h);
  endtask

  task automatic rand_release(bit take_front);
    logic [HANDLE_W-1:0] h;
    int                  k;
    if (issued.size() == 0 || $urandom_range(0, 7) == 0) begin
      h = HANDLE_W'($urandom);
    end else if (take_front) begin
      h = issued.pop_front();
    end else begin
      k = $urandom_range(0, issued.size() - 1);
      h = issued[k];
    end
    send_req(OP_RELEASE, 16'($urandom), 8'($urandom), h);
  endtask

  // Mixed traffic, weighted towards allocate and release.
  task automatic rand_mix(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) rand_alloc();
      else if (pick < 15) rand_release(0);
      else if (pick < 19)
        send_req(OP_TICK, 16'($urandom), 8'($urandom), HANDLE_W'($urandom));
      else
        send_req(OP_FLUSH, 16'($urandom), 8'($urandom), HANDLE_W'($urandom));
    end
  endtask

  initial begin
    calm      = 0;
    hold_go   = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = OP_ALLOC;
    vertex_count = '0;
    vertex_size  = '0;
    handle    = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening under the reset register values.
    send_req(OP_TICK, 16'hffff, 8'hff, '1);
    send_req(OP_FLUSH, 16'h0, 8'h0, '0);
    send_req(OP_RELEASE, 16'h0, 8'h0, 32'hdead_beef);
    send_req(OP_ALLOC, 16'd0, 8'd0, 32'h5);
    send_req(OP_ALLOC, 16'd7, 8'd9, '0);
    send_req(OP_ALLOC, 16'hffff, 8'hff, '1);
    send_req(OP_ALLOC, 16'd10, 8'd10, 32'h11);
    send_req(OP_RELEASE, 16'd0, 8'd0, 32'h11);
    send_req(OP_ALLOC, 16'd20, 8'd4, 32'h99);
    send_req(OP_RELEASE, 16'd0, 8'd0, 32'h11);
    send_req(OP_ALLOC, 16'd3, 8'd3, 32'h22);
    send_req(OP_RELEASE, 16'd0, 8'd0, '1);
    repeat (4) send_req(OP_TICK, 16'd0, 8'd0, '0);
    send_req(OP_RELEASE, 16'd0, 8'd0, 32'h5);
    send_req(OP_RELEASE, 16'd0, 8'd0, 32'h22);
    send_req(OP_FLUSH, 16'd0, 8'd0, '0);
    send_req(OP_ALLOC, 16'd0, 8'd0, '0);

    // No rounding and immediate ageing; one long hold-off on the result side.
    set_regs(32'd0, 32'd0);
    send_req(OP_ALLOC, 16'd0, 8'd0, 32'h77);
    hold_go = 1;
    rand_mix(50);

    // Widest rounding, no ageing: fill the in-use table, then the pool.
    set_regs(32'h00ff_ffff, 32'd255);
    issued.delete();
    repeat (68) rand_alloc();
    repeat (36) rand_release(1);
    repeat (3) send_req(OP_TICK, 16'd0, 8'd0, '0);

    // Random limits; the last stretch runs without idling.
    set_regs(32'($urandom_range(1, 4096)), 32'($urandom_range(1, 4)));
    rand_mix(30);
    calm = 1;
    rand_mix(25);

    wait_drained();
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("buffer_recycle_pool_with_aging: match");
    end else begin
      $display("buffer_recycle_pool_with_aging: mismatch");
    end
    $finish;
  end

endmodule
